[sv/keystream_byte_decrypt_core_assert.svh]
// assertion macros for the keystream byte decrypt core
`ifndef KEYSTREAM_BYTE_DECRYPT_CORE_ASSERT_SVH
`define KEYSTREAM_BYTE_DECRYPT_CORE_ASSERT_SVH

// clocked check, off while reset is asserted
`define KBD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define KBD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/kbd_pkg.sv]
// shared types and constants of the keystream byte decrypt core
package kbd_pkg;

	localparam int unsigned KEY_W  = 32;
	localparam int unsigned HALF_W = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_W  = 32;
	localparam int unsigned IDX_W  = 2;

	localparam logic [14:0] MUL_A = 15'd20021;
	localparam logic [8:0]  MUL_B = 9'd346;

	typedef enum logic [IDX_W-1:0] {
		REG_SEED_KEY     = 2'd0,
		REG_MAGIC_FIRST  = 2'd1,
		REG_MAGIC_SECOND = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] cipher_byte;
		logic              last_byte;
	} in_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] plain_byte;
		logic [BYTE_W-1:0] sum_so_far;
		logic [BYTE_W-1:0] xor_so_far;
		logic              end_of_buffer;
	} out_req_t;

endpackage

[sv/keystream_byte_decrypt_core.sv]
// keystream byte decrypt core: key recurrence, byte decrypt and running checks
//
// usage
//   in channel  : in_valid / in_ready / in_data, one ciphertext byte per request,
//                 with last_byte marking the final byte of a buffer
//   out channel : out_valid / out_ready / out_data, exactly one result per request:
//                 plaintext byte, running sum, running xor, end-of-buffer flag
//   cfg port    : cfg_write / cfg_index / cfg_data, single-cycle writes of the
//                 seed key and the two magic bytes; index 3 is ignored
// result register and throughput
//   a result is loaded into the output register by the edge that takes its request
//   one request per cycle while the output is not stalled; the key step (three constant
//   multiplies and three adds into the key register) is combinational
// reset
//   all registers but the result payload reset, the next request starts a buffer from
//   seed_key; a seed written before the first byte of a buffer is used by that buffer
// stalls
//   while a result waits and out_ready is low it holds and in_ready drops; a request is
//   still taken in the same cycle the held result drains
module keystream_byte_decrypt_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  kbd_pkg::in_req_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output kbd_pkg::out_req_t             out_data,
	input  logic                          cfg_write,
	input  logic [kbd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [kbd_pkg::CFG_W-1:0]     cfg_data
);
	import kbd_pkg::*;

	// configuration registers
	logic [KEY_W-1:0]  seed_q;
	logic [BYTE_W-1:0] magic_first_q;
	logic [BYTE_W-1:0] magic_second_q;

	// buffer state
	logic [KEY_W-1:0]  key_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] xor_q;
	logic              at_start_q;

	// output register
	logic     out_valid_q;
	out_req_t out_data_q;

	logic              in_acc;
	logic [KEY_W-1:0]  cur_key;
	logic [BYTE_W-1:0] cur_sum;
	logic [BYTE_W-1:0] cur_xor;
	logic [KEY_W-1:0]  lo_prod;
	logic [KEY_W-1:0]  hi_word;
	logic [KEY_W-1:0]  hi_prod;
	logic [KEY_W-1:0]  mix_prod;
	logic [KEY_W-1:0]  hi_sum;
	logic [HALF_W-1:0] hi_half;
	logic [KEY_W-1:0]  next_key;
	logic [BYTE_W-1:0] ks_byte;
	logic [BYTE_W-1:0] plain;
	logic [BYTE_W-1:0] new_sum;
	logic [BYTE_W-1:0] new_xor;

	// result register drains or is empty -> room for a new request
	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a new buffer starts from the seed with cleared checks
	assign cur_key = at_start_q ? seed_q : key_q;
	assign cur_sum = at_start_q ? '0 : sum_q;
	assign cur_xor = at_start_q ? '0 : xor_q;

	// key step, all modulo 2^32
	assign lo_prod  = {{HALF_W{1'b0}}, cur_key[HALF_W-1:0]} * {{(KEY_W-15){1'b0}}, MUL_A};
	assign hi_word  = {magic_second_q, magic_first_q, cur_key[KEY_W-1:HALF_W]};
	assign hi_prod  = hi_word * {{(KEY_W-15){1'b0}}, MUL_A};
	assign mix_prod = cur_key * {{(KEY_W-9){1'b0}}, MUL_B};
	assign hi_sum   = hi_prod + mix_prod + {{HALF_W{1'b0}}, lo_prod[KEY_W-1:HALF_W]};
	assign hi_half  = hi_sum[HALF_W-1:0];
	assign next_key = {hi_half, lo_prod[HALF_W-1:0]} + {{(KEY_W-1){1'b0}}, 1'b1};

	// keystream byte is the low byte of the upper half (bit 15 masked off anyway)
	assign ks_byte = hi_half[BYTE_W-1:0];
	assign plain   = in_data.cipher_byte - ks_byte;
	assign new_sum = cur_sum + plain;
	assign new_xor = cur_xor ^ plain;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q         <= '0;
			magic_first_q  <= '0;
			magic_second_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SEED_KEY:     seed_q         <= cfg_data;
				REG_MAGIC_FIRST:  magic_first_q  <= cfg_data[BYTE_W-1:0];
				REG_MAGIC_SECOND: magic_second_q <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// buffer state: key and running checks advance per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			sum_q      <= '0;
			xor_q      <= '0;
			at_start_q <= 1'b1;
		end else if (in_acc) begin
			key_q      <= next_key;
			sum_q      <= new_sum;
			xor_q      <= new_xor;
			// last byte: reload from the seed on the next request
			at_start_q <= in_data.last_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_data_q.plain_byte    <= plain;
			out_data_q.sum_so_far    <= new_sum;
			out_data_q.xor_so_far    <= new_xor;
			out_data_q.end_of_buffer <= in_data.last_byte;
		end
	end

	`include "keystream_byte_decrypt_core_assert.svh"

	// a taken request always lands in the result register
	`KBD_ASSERT(a_req_to_result, in_acc |=> out_valid_q, "accepted request lost")
	// a last byte makes the next request start a fresh buffer
	`KBD_ASSERT(a_last_restarts, (in_acc && in_data.last_byte) |=> at_start_q, "no restart after last byte")
	// running sum continues from the stored sum within a buffer
	`KBD_ASSERT(a_sum_chain, (in_acc && !at_start_q) |=> (out_data_q.sum_so_far == BYTE_W'($past(sum_q) + out_data_q.plain_byte)), "running sum broken")
	// first result of a buffer carries its own byte as the sum
	`KBD_ASSERT_ALWAYS(a_sum_fresh, (arst_n && in_acc && at_start_q) |=> (!arst_n || out_data_q.sum_so_far == out_data_q.plain_byte), "sum not cleared at buffer start")

endmodule

[sim/keystream_byte_decrypt_core_tb.sv]
// testbench for the keystream byte decrypt core: directed and random traffic checked against a local predictor
`timescale 1ns / 100ps

module keystream_byte_decrypt_core_tb;

	import kbd_pkg::*;

	localparam logic [IDX_W-1:0] REG_NONE = 2'd3;  // index past the register list
	localparam logic [31:0] LOW_HALF = 32'h0000_ffff;
	localparam logic [31:0] KS_MASK  = 32'h0000_7fff;
	localparam int ITEM_TARGET    = 1350;
	localparam int WATCHDOG_LIMIT = 2000;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_req_t          in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_req_t         out_data;
	logic             cfg_write = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;

	// predictor copy of the registers and the running state
	logic [31:0] seed_copy;
	logic [7:0]  magic1_copy;
	logic [7:0]  magic2_copy;
	logic [31:0] key_copy;
	logic [7:0]  sum_copy;
	logic [7:0]  xor_copy;
	logic        buffer_open;

	in_req_t  cipher_q[$];
	out_req_t plain_expect_q[$];
	out_req_t expected_plain;
	int       queued_cnt   = 0;
	int       accepted_cnt = 0;
	int       fail_count   = 0;
	int       stall_cycles = 0;
	logic     req_taken    = 1'b0;

	keystream_byte_decrypt_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// one key step and decrypt per accepted request
	function automatic out_req_t decrypt_predict(in_req_t req);
		logic [31:0] k;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [7:0]  plain;
		out_req_t    res;
		if (!buffer_open) begin
			key_copy    = seed_copy;
			sum_copy    = '0;
			xor_copy    = '0;
			buffer_open = 1'b1;
		end
		k  = key_copy;
		lo = (k & LOW_HALF) * MUL_A;
		hi = {magic2_copy, magic1_copy, k[31:16]};
		hi = (hi * MUL_A + k * MUL_B + (lo >> 16)) & LOW_HALF;
		key_copy = (hi << 16) + (lo & LOW_HALF) + 32'd1;
		plain    = req.cipher_byte - 8'((hi & KS_MASK) & 32'hff);
		sum_copy = sum_copy + plain;
		xor_copy = xor_copy ^ plain;
		res.plain_byte    = plain;
		res.sum_so_far    = sum_copy;
		res.xor_so_far    = xor_copy;
		res.end_of_buffer = req.last_byte;
		if (req.last_byte) begin
			key_copy    = seed_copy;
			sum_copy    = '0;
			xor_copy    = '0;
			buffer_open = 1'b0;
		end
		return res;
	endfunction

	// driver: bursts of requests with random gaps in between
	int burst_left = 0;
	int gap_left   = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else if (!in_valid || req_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (cipher_q.size() > 0) begin
				in_valid <= 1'b1;
				in_data  <= cipher_q.pop_front();
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: modes of always ready, coin flip, and long stalls
	int ready_mode = 0;
	int mode_left  = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(16, 96);
			end else begin
				mode_left--;
			end
			case (ready_mode)
				0: begin
					out_ready <= 1'b1;
				end
				1: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					out_ready <= ($urandom_range(0, 7) == 0);
				end
			endcase
		end
	end

	// monitor: check results in order, predict each accepted request
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (plain_expect_q.size() == 0) begin
					$error("result with nothing expected: plain_byte %h", out_data.plain_byte);
					fail_count++;
				end else begin
					expected_plain = plain_expect_q.pop_front();
					if (out_data.plain_byte !== expected_plain.plain_byte) begin
						$error("plain_byte expected %h got %h",
							expected_plain.plain_byte, out_data.plain_byte);
						fail_count++;
					end
					if (out_data.sum_so_far !== expected_plain.sum_so_far) begin
						$error("sum_so_far expected %h got %h",
							expected_plain.sum_so_far, out_data.sum_so_far);
						fail_count++;
					end
					if (out_data.xor_so_far !== expected_plain.xor_so_far) begin
						$error("xor_so_far expected %h got %h",
							expected_plain.xor_so_far, out_data.xor_so_far);
						fail_count++;
					end
					if (out_data.end_of_buffer !== expected_plain.end_of_buffer) begin
						$error("end_of_buffer expected %b got %b",
							expected_plain.end_of_buffer, out_data.end_of_buffer);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				plain_expect_q.push_back(decrypt_predict(in_data));
				accepted_cnt++;
			end
			req_taken <= in_valid && in_ready;
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic queue_item(input logic [7:0] cipher, input logic last);
		in_req_t req;
		req.cipher_byte = cipher;
		req.last_byte   = last;
		cipher_q.push_back(req);
		queued_cnt++;
	endtask

	// returns at a falling edge once every request is taken and every result is in
	task automatic wait_idle();
		@(negedge clk);
		while (accepted_cnt != queued_cnt || plain_expect_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_SEED_KEY: begin
				seed_copy = value;
			end
			REG_MAGIC_FIRST: begin
				magic1_copy = value[7:0];
			end
			REG_MAGIC_SECOND: begin
				magic2_copy = value[7:0];
			end
			default: begin
			end
		endcase
	endtask

	// zero, all ones or random, upper bits beyond a register's width included
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 3))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int n;
		int buf_left;
		int phase;
		seed_copy   = '0;
		magic1_copy = '0;
		magic2_copy = '0;
		key_copy    = '0;
		sum_copy    = '0;
		xor_copy    = '0;
		buffer_open = 1'b0;
		buf_left    = 0;
		phase       = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: zero seed and zero magic bytes
		queue_item(8'h00, 1'b0);
		queue_item(8'hff, 1'b0);
		queue_item(8'h80, 1'b1);
		wait_idle();

		// all-ones extremes, then a write to the unused index that must be dropped
		write_reg(REG_SEED_KEY, 32'hffff_ffff);
		write_reg(REG_MAGIC_FIRST, 32'hffff_ffff);
		write_reg(REG_MAGIC_SECOND, 32'h0000_00ff);
		write_reg(REG_NONE, 32'h0000_0000);
		@(posedge clk);
		queue_item(8'h00, 1'b0);
		queue_item(8'hff, 1'b0);
		queue_item(8'h01, 1'b0);
		wait_idle();

		// mid-buffer writes: seed waits for the next buffer, magic applies on the next step
		write_reg(REG_SEED_KEY, 32'h1234_5678);
		write_reg(REG_MAGIC_FIRST, 32'hffff_ff5a);
		@(posedge clk);
		queue_item(8'h7f, 1'b0);
		queue_item(8'hfe, 1'b1);
		queue_item(8'h00, 1'b1);
		queue_item(8'hff, 1'b1);
		wait_idle();

		write_reg(REG_MAGIC_FIRST, 32'h0000_0000);
		write_reg(REG_MAGIC_SECOND, 32'hffff_ff00);
		write_reg(REG_SEED_KEY, 32'h0000_0000);
		@(posedge clk);
		queue_item(8'ha5, 1'b0);
		queue_item(8'h5a, 1'b1);

		// random phases; buffers run across phase boundaries so some writes land mid-buffer
		while (queued_cnt < ITEM_TARGET) begin
			wait_idle();
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_SEED_KEY, pick_word());
			if (phase % 4 == 0) begin
				write_reg(REG_MAGIC_FIRST, 32'h0000_0000);
				write_reg(REG_MAGIC_SECOND, 32'h0000_0000);
			end else begin
				if ($urandom_range(0, 2) != 0)
					write_reg(REG_MAGIC_FIRST, pick_word());
				if ($urandom_range(0, 2) != 0)
					write_reg(REG_MAGIC_SECOND, pick_word());
			end
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_NONE, $urandom());
			@(posedge clk);
			n = $urandom_range(40, 140);
			for (int i = 0; i < n; i++) begin
				if (buf_left == 0)
					buf_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120)
						: $urandom_range(1, 12);
				buf_left--;
				queue_item(8'($urandom_range(0, 255)), buf_left == 0);
			end
			phase++;
		end

		wait_idle();
		repeat (5) @(posedge clk);
		if (plain_expect_q.size() != 0) begin
			$error("%0d results never arrived", plain_expect_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/kbd_pkg.sv
sv/keystream_byte_decrypt_core.sv
sim/keystream_byte_decrypt_core_tb.sv
